// ===== rtl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Shared command codes, queue item type and sizing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

  // Command codes as they arrive on the input stream.
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned TOP_BIT       = 7;
  localparam int unsigned HALF_W        = 16;
  localparam logic [HALF_W-1:0] HALF_RESET = 16'd250;

  // Queue between the front and the back: two entries, one pointer bit.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  // One classified item travelling from the front to the back.
  typedef struct packed {
    cmd_t       kind;
    logic [7:0] wbyte;
    logic       ack_after_read;
    logic       sda_sample;
  } item_t;

  // Handshake between the queue head and the engine.
  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

endpackage

`default_nettype wire

// ===== rtl/i2cm_front.sv =====
// ----------------------------------------------------------------------------
// I2C master front end
// Accepts input items, maps unused command codes to none and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [2:0]    in_cmd,
  input  wire logic [7:0]    in_wbyte,
  input  wire logic          in_ack,
  input  wire logic          in_sda,
  output i2cm_pkg::qhead_t   head,
  input  wire logic          pop
);

  localparam int unsigned QCNT_W = i2cm_pkg::QCNT_W;

  i2cm_pkg::item_t                  q_mem [i2cm_pkg::QDEPTH];
  logic [i2cm_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [i2cm_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [i2cm_pkg::QCNT_W-1:0]      count_r, count_nxt;
  i2cm_pkg::item_t                  item_in;
  logic                             push;

  // Codes five to seven carry no command and are treated as none.
  always_comb begin
    item_in.wbyte          = in_wbyte;
    item_in.ack_after_read = in_ack;
    item_in.sda_sample     = in_sda;
    unique case (in_cmd) inside
      i2cm_pkg::CMD_START, i2cm_pkg::CMD_STOP,
      i2cm_pkg::CMD_WRITE, i2cm_pkg::CMD_READ: item_in.kind = i2cm_pkg::cmd_t'(in_cmd);
      default:                                 item_in.kind = i2cm_pkg::CMD_NONE;
    endcase
  end

  assign in_ready = (count_r != i2cm_pkg::QCNT_W'(i2cm_pkg::QDEPTH));
  assign push     = in_valid && in_ready;

  assign head.valid = (count_r != '0);
  assign head.item  = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(i2cm_pkg::QDEPTH))
    else $error("queue count above depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ===== rtl/i2cm_back.sv =====
// ----------------------------------------------------------------------------
// I2C master back end
// Runs the line sequences one tick per item and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [i2cm_pkg::HALF_W-1:0]   half_period,
  input  wire i2cm_pkg::qhead_t              head,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [15:0]                        out_data
);

  localparam int unsigned HW = i2cm_pkg::HALF_W;

  i2cm_pkg::cmd_t  active_r, active_nxt;
  logic [HW-1:0]   tick_r, tick_nxt;
  logic [1:0]      phase_r, phase_nxt;
  logic [3:0]      bit_r, bit_nxt;
  logic [7:0]      shift_r, shift_nxt;
  logic            scl_r, scl_nxt;
  logic            sda_r, sda_nxt;
  logic            ackc_r, ackc_nxt;
  logic            nack_r, nack_nxt;
  logic [7:0]      rx_r, rx_nxt;
  logic            out_valid_r;
  logic [15:0]     out_data_r;

  logic [HW-1:0]   limit;
  logic [HW-1:0]   tick_inc;
  logic            fire;
  logic            complete;
  logic            in_byte;
  logic [7:0]      shift_in;
  i2cm_pkg::item_t it;

  assign it  = head.item;
  assign pop = head.valid && (!out_valid_r || out_ready);

  // A half period of zero behaves as one tick.
  assign limit    = (half_period == '0) ? HW'(1) : half_period;
  assign tick_inc = tick_r + HW'(1);
  assign fire     = (tick_inc >= limit);
  assign in_byte  = (bit_r < 4'(i2cm_pkg::BITS_PER_BYTE));
  assign shift_in = {shift_r[6:0], it.sda_sample};

  // The last action of each sequence ends the command.
  always_comb begin
    complete = 1'b0;
    unique case (active_r)
      i2cm_pkg::CMD_START,
      i2cm_pkg::CMD_STOP:  complete = (phase_r == 2'd3);
      i2cm_pkg::CMD_WRITE,
      i2cm_pkg::CMD_READ:  complete = !in_byte && (phase_r != 2'd0);
      default:             complete = 1'b1;
    endcase
  end

  // Next state of the command sequencer.
  always_comb begin
    active_nxt = active_r;
    if (pop) begin
      if (active_r == i2cm_pkg::CMD_NONE) begin
        active_nxt = it.kind;
      end else if (fire && complete) begin
        active_nxt = i2cm_pkg::CMD_NONE;
      end
    end
  end

  // Line levels, counters and data registers.
  always_comb begin
    tick_nxt  = tick_r;
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ackc_nxt  = ackc_r;
    nack_nxt  = nack_r;
    rx_nxt    = rx_r;
    if (pop) begin
      if (active_r == i2cm_pkg::CMD_NONE) begin
        if (it.kind != i2cm_pkg::CMD_NONE) begin
          tick_nxt  = '0;
          phase_nxt = '0;
          bit_nxt   = '0;
        end
        if (it.kind == i2cm_pkg::CMD_WRITE) begin
          shift_nxt = it.wbyte;
        end
        if (it.kind == i2cm_pkg::CMD_READ) begin
          shift_nxt = '0;
          ackc_nxt  = it.ack_after_read;
          sda_nxt   = 1'b1;
        end
      end else if (!fire) begin
        tick_nxt = tick_inc;
      end else begin
        tick_nxt = '0;
        unique case (active_r)
          i2cm_pkg::CMD_START: begin
            case (phase_r)
              2'd0:    sda_nxt = 1'b1;
              2'd1:    scl_nxt = 1'b1;
              2'd2:    sda_nxt = 1'b0;
              default: scl_nxt = 1'b0;
            endcase
            phase_nxt = phase_r + 2'd1;
          end
          i2cm_pkg::CMD_STOP: begin
            case (phase_r)
              2'd0:    sda_nxt = 1'b0;
              2'd1:    scl_nxt = 1'b0;
              2'd2:    scl_nxt = 1'b1;
              default: sda_nxt = 1'b1;
            endcase
            phase_nxt = phase_r + 2'd1;
          end
          i2cm_pkg::CMD_WRITE: begin
            if (in_byte) begin
              case (phase_r)
                2'd0: begin
                  sda_nxt   = shift_r[3'(i2cm_pkg::TOP_BIT) - bit_r[2:0]];
                  phase_nxt = 2'd1;
                end
                2'd1: begin
                  scl_nxt   = 1'b1;
                  phase_nxt = 2'd2;
                end
                default: begin
                  scl_nxt   = 1'b0;
                  phase_nxt = 2'd0;
                  bit_nxt   = bit_r + 4'd1;
                  // Release SDA for the acknowledge after the last bit.
                  if (bit_r == 4'(i2cm_pkg::TOP_BIT)) begin
                    sda_nxt = 1'b1;
                  end
                end
              endcase
            end else if (phase_r == 2'd0) begin
              scl_nxt   = 1'b1;
              phase_nxt = 2'd1;
            end else begin
              nack_nxt = it.sda_sample;
              scl_nxt  = 1'b0;
            end
          end
          i2cm_pkg::CMD_READ: begin
            if (in_byte) begin
              if (phase_r == 2'd0) begin
                scl_nxt   = 1'b1;
                phase_nxt = 2'd1;
              end else begin
                shift_nxt = shift_in;
                scl_nxt   = 1'b0;
                phase_nxt = 2'd0;
                bit_nxt   = bit_r + 4'd1;
                if (bit_r == 4'(i2cm_pkg::TOP_BIT)) begin
                  rx_nxt = shift_in;
                end
              end
            end else if (phase_r == 2'd0) begin
              sda_nxt   = !ackc_r;
              scl_nxt   = 1'b1;
              phase_nxt = 2'd1;
            end else begin
              scl_nxt = 1'b0;
            end
          end
          default: begin
          end
        endcase
        if (complete) begin
          phase_nxt = '0;
          bit_nxt   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= i2cm_pkg::CMD_NONE;
      tick_r      <= '0;
      phase_r     <= '0;
      bit_r       <= '0;
      shift_r     <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      ackc_r      <= 1'b0;
      nack_r      <= 1'b0;
      rx_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      tick_r   <= tick_nxt;
      phase_r  <= phase_nxt;
      bit_r    <= bit_nxt;
      shift_r  <= shift_nxt;
      scl_r    <= scl_nxt;
      sda_r    <= sda_nxt;
      ackc_r   <= ackc_nxt;
      nack_r   <= nack_nxt;
      rx_r     <= rx_nxt;
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result fields from bit 0 up: scl, sda, busy, done, read byte, nack.
  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= {3'b000, nack_nxt, rx_nxt,
                     (fire && complete && active_r != i2cm_pkg::CMD_NONE),
                     (active_nxt != i2cm_pkg::CMD_NONE), sda_nxt, scl_nxt};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r == i2cm_pkg::CMD_NONE) |-> (phase_r == '0 && bit_r == '0))
    else $error("idle engine with live sequence counters");

  a_bit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bit_r <= 4'(i2cm_pkg::BITS_PER_BYTE))
    else $error("bit index past one byte");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[3]) |-> !out_data_r[2])
    else $error("done flagged while still busy");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(active_r))
    else $error("engine advanced while result stalled");
`endif

endmodule

`default_nettype wire

// ===== rtl/i2c_master_byte_engine.sv =====
// ----------------------------------------------------------------------------
// I2C master byte engine
// Tick-driven I2C master: start, stop, write byte and read byte sequences.
// ----------------------------------------------------------------------------
// Path: an accepted item is queued, then its result is registered on pop.
// Throughput: one item per cycle unless the result side stalls; the engine
//   takes one queued item per cycle and the output register refills in the
//   cycle it is drained.
// Reset: synchronous active-low rst_n clears the queue and the engine,
//   releases SCL and SDA and sets the half period to 250 ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata: [7:0] write_byte, [8] ack_after_read, [9] sda_sample, rest zero.
  input  wire logic [15:0] in_tdata,
  // tuser: [2:0] cmd.
  input  wire logic [2:0]  in_tuser,
  // Result stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata: [0] scl_level, [1] sda_level, [2] busy_res, [3] done_res,
  //        [11:4] read_byte, [12] nack_seen, rest zero.
  output logic [15:0]      out_tdata,
  // Configuration port.
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  // The only register, half_period_ticks, sits at byte address zero, so
  // every access within the two-bit address space hits it.
  logic [i2cm_pkg::HALF_W-1:0] half_r;
  logic                        cfg_wr;

  i2cm_pkg::qhead_t head;
  logic             pop;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[1:0] <= 2'd3);
  assign cfg_prdata = {16'h0000, half_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= i2cm_pkg::HALF_RESET;
    end else if (cfg_wr) begin
      half_r <= cfg_pwdata[i2cm_pkg::HALF_W-1:0];
    end
  end

  // Front end: command classification and a two-entry queue, so the input
  // side keeps flowing while a result waits on the output.
  i2cm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_cmd   (in_tuser),
    .in_wbyte (in_tdata[7:0]),
    .in_ack   (in_tdata[8]),
    .in_sda   (in_tdata[9]),
    .head     (head),
    .pop      (pop)
  );

  // Back end: one engine step per item, result held in an output register.
  i2cm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .half_period (half_r),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_data    (out_tdata)
  );

endmodule

`default_nettype wire

// ===== tb/i2c_master_byte_engine_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master byte engine checker
// Watches the input, result and configuration ports of the byte engine,
// predicts the line status for every input item and compares each result
// item against the oldest prediction, field by field.
// ----------------------------------------------------------------------------

module i2c_master_byte_engine_checker #(
  parameter logic [1:0] HALF_PERIOD_ADDR = 2'd0
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [15:0] in_tdata,
  input  wire logic [2:0]  in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [15:0] out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  input  wire logic        cfg_pready,
  input  wire logic        end_check,
  output int               failures
);
  import i2cm_pkg::*;

  // Laid out as out_tdata[12:0].
  typedef struct packed {
    logic       nack_seen;
    logic [7:0] read_byte;
    logic       done;
    logic       busy;
    logic       sda;
    logic       scl;
  } line_status_t;

  logic [HALF_W-1:0] half_period;
  logic [HALF_W-1:0] tick_cnt;
  logic [2:0]        step_no;
  logic [3:0]        bit_no;
  logic [7:0]        shifter;
  logic [7:0]        rx_byte;
  cmd_t              running;
  logic              scl_q;
  logic              sda_q;
  logic              send_ack;
  logic              nack_q;

  line_status_t      status_queue [$];
  line_status_t      want;
  bit                end_seen;

  function automatic void clear_engine();
    half_period = HALF_RESET;
    tick_cnt    = '0;
    step_no     = '0;
    bit_no      = '0;
    shifter     = '0;
    rx_byte     = '0;
    running     = CMD_NONE;
    scl_q       = 1'b1;
    sda_q       = 1'b1;
    send_ack    = 1'b0;
    nack_q      = 1'b0;
  endfunction

  // Carries out the next line action of the running command and returns 1
  // when that action was the last one.
  function automatic bit line_action(input logic sda_in);
    case (running)
      CMD_START: begin
        case (step_no)
          3'd0: sda_q = 1'b1;
          3'd1: scl_q = 1'b1;
          3'd2: sda_q = 1'b0;
          default: begin
            scl_q = 1'b0;
            return 1'b1;
          end
        endcase
        step_no++;
        return 1'b0;
      end
      CMD_STOP: begin
        case (step_no)
          3'd0: sda_q = 1'b0;
          3'd1: scl_q = 1'b0;
          3'd2: scl_q = 1'b1;
          default: begin
            sda_q = 1'b1;
            return 1'b1;
          end
        endcase
        step_no++;
        return 1'b0;
      end
      CMD_WRITE: begin
        if (bit_no < BITS_PER_BYTE) begin
          if (step_no == 3'd0) begin
            sda_q   = shifter[TOP_BIT - bit_no];
            step_no = 3'd1;
          end else if (step_no == 3'd1) begin
            scl_q   = 1'b1;
            step_no = 3'd2;
          end else begin
            scl_q   = 1'b0;
            step_no = 3'd0;
            bit_no++;
            // SDA is released for the target's acknowledge.
            if (bit_no == BITS_PER_BYTE) sda_q = 1'b1;
          end
          return 1'b0;
        end
        if (step_no == 3'd0) begin
          scl_q   = 1'b1;
          step_no = 3'd1;
          return 1'b0;
        end
        nack_q = sda_in;
        scl_q  = 1'b0;
        return 1'b1;
      end
      CMD_READ: begin
        if (bit_no < BITS_PER_BYTE) begin
          if (step_no == 3'd0) begin
            scl_q   = 1'b1;
            step_no = 3'd1;
          end else begin
            shifter = {shifter[6:0], sda_in};
            scl_q   = 1'b0;
            step_no = 3'd0;
            bit_no++;
            if (bit_no == BITS_PER_BYTE) rx_byte = shifter;
          end
          return 1'b0;
        end
        if (step_no == 3'd0) begin
          sda_q   = ~send_ack;
          scl_q   = 1'b1;
          step_no = 3'd1;
          return 1'b0;
        end
        scl_q = 1'b0;
        return 1'b1;
      end
      default: return 1'b1;
    endcase
  endfunction

  // One clock tick of the engine; returns the line status after it.
  function automatic line_status_t engine_tick(input logic [2:0] cmd,
                                               input logic [7:0] wbyte,
                                               input logic       ackr,
                                               input logic       sda_in);
    line_status_t st;
    logic [HALF_W-1:0] limit;
    st.done = 1'b0;
    limit = (half_period == '0) ? HALF_W'(1) : half_period;
    if (running == CMD_NONE) begin
      // Codes past the read command are ignored like an empty tick.
      if (cmd >= CMD_START && cmd <= CMD_READ) begin
        running  = cmd_t'(cmd);
        tick_cnt = '0;
        step_no  = '0;
        bit_no   = '0;
        if (cmd == CMD_WRITE) shifter = wbyte;
        if (cmd == CMD_READ) begin
          shifter  = '0;
          send_ack = ackr;
          sda_q    = 1'b1;
        end
      end
    end else begin
      tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= limit) begin
        tick_cnt = '0;
        if (line_action(sda_in)) begin
          running = CMD_NONE;
          step_no = '0;
          bit_no  = '0;
          st.done = 1'b1;
        end
      end
    end
    st.scl       = scl_q;
    st.sda       = sda_q;
    st.busy      = (running != CMD_NONE);
    st.read_byte = rx_byte;
    st.nack_seen = nack_q;
    return st;
  endfunction

  task automatic compare_field(input string what, input int unsigned exp_val,
                               input int unsigned got_val);
    if (exp_val != got_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_val,
               got_val);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_engine();
      status_queue.delete();
      failures = 0;
      end_seen = 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == HALF_PERIOD_ADDR) begin
        half_period = cfg_pwdata[HALF_W-1:0];
      end
      if (in_tvalid && in_tready) begin
        status_queue.push_back(engine_tick(in_tuser, in_tdata[7:0], in_tdata[8],
                                           in_tdata[9]));
      end
      if (out_tvalid && out_tready) begin
        if (status_queue.size() == 0) begin
          $display("%0t: unexpected result item, expected none, actual %h", $time,
                   out_tdata);
          failures++;
        end else begin
          want = status_queue.pop_front();
          compare_field("scl_level", want.scl, out_tdata[0]);
          compare_field("sda_level", want.sda, out_tdata[1]);
          compare_field("busy_res", want.busy, out_tdata[2]);
          compare_field("done_res", want.done, out_tdata[3]);
          compare_field("read_byte", want.read_byte, out_tdata[11:4]);
          compare_field("nack_seen", want.nack_seen, out_tdata[12]);
          compare_field("tdata padding", 0, out_tdata[15:13]);
        end
      end
      if (end_check && !end_seen) begin
        end_seen = 1'b1;
        if (status_queue.size() != 0) begin
          $display("%0t: results missing, expected %0d more, actual 0", $time,
                   status_queue.size());
          failures += status_queue.size();
        end
      end
    end
  end

endmodule

// ===== tb/i2c_master_byte_engine_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master byte engine testbench
// Drives clock ticks with commands into the byte engine, programs the half
// period through the configuration port and leaves all checking to the
// checker instance. Prints the verdict once every result has come back.
// ----------------------------------------------------------------------------

module i2c_master_byte_engine_tb;
  import i2cm_pkg::*;

  localparam logic [1:0] HALF_PERIOD_ADDR = 2'd0;
  // Number of distinct values the 3-bit command field can carry.
  localparam int CMD_CODES    = 8;
  localparam int RANDOM_ITEMS = 150;
  localparam int PHASES       = 3;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 10;
  // Roughly 500 items plus the long hold, taken many times over.
  localparam int CYCLE_LIMIT  = 200000;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata    = '0;
  logic [2:0]  in_tuser    = '0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [1:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        end_check   = 1'b0;
  int          failures;

  // Handshake bookkeeping. cycle_count, in_count, out_count and done_total are
  // nonblocking, so the stimulus process always sees last cycle's values.
  int cycle_count = 0;
  int in_count    = 0;
  int out_count   = 0;
  int done_total  = 0;
  int done_mark   = 0;
  int items_sent  = 0;

  // Idling control; gaps_on and holds_asked are shared with the result side.
  bit gaps_on      = 1'b0;
  int holds_asked  = 0;
  int holds_served = 0;
  int hold_left    = 0;
  int stall_left   = 0;

  int unsigned half_settings [PHASES] = '{1, 2, 0};

  i2c_master_byte_engine uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  i2c_master_byte_engine_checker #(
    .HALF_PERIOD_ADDR (HALF_PERIOD_ADDR)
  ) line_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .end_check   (end_check),
    .failures    (failures)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Cycle budget and input-side item count.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
    if (in_tvalid && in_tready) in_count <= in_count + 1;
  end

  // Result side. It normally accepts every item, stalls in short random
  // bursts while gaps are enabled, and on request holds off for a long
  // stretch so that the engine's queue fills and in_tready drops while the
  // sender keeps offering ticks.
  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      out_count <= out_count + 1;
      if (out_tdata[3]) done_total <= done_total + 1;
    end
    if (holds_served != holds_asked) begin
      holds_served = holds_served + 1;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left  = hold_left - 1;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Offers one tick and waits until the engine takes it. The valid line is
  // left high on return so back-to-back ticks follow without an idle gap.
  task automatic send_tick(input logic [2:0] cmd, input logic [7:0] wbyte,
                           input logic ackr, input logic sda);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {6'b0, sda, ackr, wbyte};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // A tick with a random SDA sample. With stray set, it now and then carries
  // a command too; while the engine is busy that command must be ignored.
  task automatic noise_tick(input bit stray);
    logic [2:0] cmd;
    cmd = CMD_NONE;
    if (stray && $urandom_range(0, 9) == 0) begin
      cmd = 3'($urandom_range(CMD_START, CMD_CODES - 1));
    end
    send_tick(cmd, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // Commands are offered on a single tick only. The next command waits until
  // a finished result has come back, so an offered command lands on an idle
  // engine unless a stray tick has started one; real transactions get through.
  task automatic offer_command(input logic [2:0] cmd, input logic [7:0] wbyte,
                               input logic ackr);
    done_mark = done_total;
    send_tick(cmd, wbyte, ackr, 1'($urandom));
  endtask

  task automatic finish_command(input bit stray);
    while (done_total == done_mark) noise_tick(stray);
  endtask

  task automatic run_command(input logic [2:0] cmd, input logic [7:0] wbyte,
                             input logic ackr);
    offer_command(cmd, wbyte, ackr);
    finish_command(1'b1);
  endtask

  // A few idle ticks, some of them with the unused command codes.
  task automatic idle_gap();
    logic [2:0] cmd;
    repeat ($urandom_range(0, 3)) begin
      cmd = ($urandom_range(0, 1) == 0) ? CMD_NONE
                                         : 3'($urandom_range(CMD_READ + 1, CMD_CODES - 1));
      send_tick(cmd, 8'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  // Mostly a framed transaction: start, address byte, up to two data bytes
  // in either direction, stop. Now and then a loose run of commands instead.
  task automatic run_transaction();
    int n;
    n = $urandom_range(0, 2);
    if ($urandom_range(0, 5) == 0) begin
      repeat (n) begin
        idle_gap();
        run_command(3'($urandom_range(CMD_START, CMD_READ)), 8'($urandom),
                    1'($urandom));
      end
    end else begin
      run_command(CMD_START, 8'($urandom), 1'($urandom));
      run_command(CMD_WRITE, 8'($urandom), 1'($urandom));
      repeat (n) begin
        idle_gap();
        if ($urandom_range(0, 1) == 0) begin
          run_command(CMD_WRITE, 8'($urandom), 1'($urandom));
        end else begin
          run_command(CMD_READ, 8'($urandom), 1'($urandom));
        end
      end
      run_command(CMD_STOP, 8'($urandom), 1'($urandom));
    end
    idle_gap();
  endtask

  // Drops valid and waits until every accepted item has its result back.
  // Each tick gives exactly one result, so no further wait is needed before
  // touching the configuration.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (out_count != in_count);
  endtask

  task automatic cfg_write(input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= HALF_PERIOD_ADDR;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  initial begin
    int target;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    gaps_on = 1'b1;

    // Reset half period: start a command, let a dozen ticks pass, then
    // shrink the half period below the running count. The next action must
    // fire on the very next tick.
    offer_command(CMD_START, 8'h00, 1'b0);
    repeat (12) noise_tick(1'b0);
    wait_drained();
    cfg_write(32'd5);
    finish_command(1'b0);

    // A zero half period behaves as one tick. The upper data bits carry
    // junk that the register must drop.
    wait_drained();
    cfg_write({16'hA5C3, 16'h0000});
    for (int c = CMD_READ + 1; c < CMD_CODES; c++) begin
      send_tick(3'(c), 8'($urandom), 1'($urandom), 1'($urandom));
    end
    run_command(CMD_START, 8'h00, 1'b0);
    run_command(CMD_WRITE, 8'hFF, 1'b0);
    run_command(CMD_WRITE, 8'h00, 1'b1);
    run_command(CMD_READ, 8'h00, 1'b1);
    run_command(CMD_READ, 8'hFF, 1'b0);
    run_command(CMD_STOP, 8'h00, 1'b0);

    // Largest half period, then cut it short in the middle of a write.
    wait_drained();
    cfg_write(32'hFFFF_FFFF);
    offer_command(CMD_WRITE, 8'h5A, 1'b0);
    repeat (20) noise_tick(1'b1);
    wait_drained();
    cfg_write(32'd1);
    finish_command(1'b1);

    // Random transactions over several half periods. The second phase asks
    // for the long hold-off on the result side; the last one runs without
    // any idling on either side.
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      cfg_write(half_settings[p]);
      gaps_on = (p != PHASES - 1);
      if (p == 1) holds_asked++;
      target = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < target) run_transaction();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    end_check <= 1'b1;
    repeat (2) @(posedge clk);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/i2cm_pkg.sv
rtl/i2cm_front.sv
rtl/i2cm_back.sv
rtl/i2c_master_byte_engine.sv
tb/i2c_master_byte_engine_checker.sv
tb/i2c_master_byte_engine_tb.sv
